// ----- hw/rtl/gdda_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian date day arithmetic package
// Shared types, selector codes and constants for the date core.
// ----------------------------------------------------------------------------
package gdda_pkg;

	localparam int DIV_W = 28;
	localparam int DVS_W = 21;
	localparam int RCP_W = 25;

	// floor(2^DIV_W / divisor) for each constant divisor
	localparam logic [RCP_W-1:0] RCP_100     = RCP_W'((64'd1 << DIV_W) / 64'd100);
	localparam logic [RCP_W-1:0] RCP_146097  = RCP_W'((64'd1 << DIV_W) / 64'd146097);
	localparam logic [RCP_W-1:0] RCP_1461001 = RCP_W'((64'd1 << DIV_W) / 64'd1461001);
	localparam logic [RCP_W-1:0] RCP_2447    = RCP_W'((64'd1 << DIV_W) / 64'd2447);
	localparam logic [RCP_W-1:0] RCP_80      = RCP_W'((64'd1 << DIV_W) / 64'd80);
	localparam logic [RCP_W-1:0] RCP_11      = RCP_W'((64'd1 << DIV_W) / 64'd11);

	localparam logic [1:0] FUNC_SET  = 2'd0;
	localparam logic [1:0] FUNC_ADD  = 2'd1;
	localparam logic [1:0] FUNC_DIFF = 2'd2;

	localparam logic [3:0]  DEF_MONTH = 4'd5;
	localparam logic [4:0]  DEF_DAY   = 5'd11;
	localparam logic [13:0] DEF_YEAR  = 14'd1959;
	localparam logic [22:0] DEF_JD    = 23'd2436700;
	localparam logic [22:0] JD_MIN    = 23'd1721060;
	localparam logic [22:0] JD_MAX    = 23'd5373484;
	localparam logic [13:0] YEAR_MAX  = 14'd9999;

	typedef enum logic [5:0] {
		STEP_FWD = 6'b000001,
		STEP_N   = 6'b000010,
		STEP_I   = 6'b000100,
		STEP_J   = 6'b001000,
		STEP_K   = 6'b010000,
		STEP_L   = 6'b100000
	} step_t;

	typedef struct packed {
		logic  load;
		logic  route;
		logic  div_start;
		logic  capture;
		logic  commit;
		step_t step;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       oor;
		logic       div_done;
	} dp_sts_t;

	// floor(367 * M / 12) with M the month shifted so that March is first
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd0:    r = 9'd305;
			4'd1:    r = 9'd336;
			4'd2:    r = 9'd367;
			4'd3:    r = 9'd30;
			4'd4:    r = 9'd61;
			4'd5:    r = 9'd91;
			4'd6:    r = 9'd122;
			4'd7:    r = 9'd152;
			4'd8:    r = 9'd183;
			4'd9:    r = 9'd214;
			4'd10:   r = 9'd244;
			4'd11:   r = 9'd275;
			4'd12:   r = 9'd305;
			4'd13:   r = 9'd336;
			4'd14:   r = 9'd367;
			default: r = 9'd397;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/gdda_div.sv -----
// ----------------------------------------------------------------------------
// Constant divider
// Reciprocal multiply with one correction step; operands, product, estimate and
// corrected quotient are registered in turn, and done pulses with the quotient.
// ----------------------------------------------------------------------------
module gdda_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gdda_pkg::DIV_W-1:0]  dividend,
	input  logic [gdda_pkg::DVS_W-1:0]  divisor,
	input  logic [gdda_pkg::RCP_W-1:0]  recip,
	output logic                        done,
	output logic [gdda_pkg::DIV_W-1:0]  quotient
);
	import gdda_pkg::*;

	localparam int PRD_W = DIV_W + RCP_W;
	localparam int QD_W  = RCP_W + DVS_W;

	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [RCP_W-1:0] rcp_q;
	logic [PRD_W-1:0] prod_s1;
	logic [RCP_W-1:0] qe_s2;
	logic [QD_W-1:0]  qd_s2;
	logic [DIV_W-1:0] quo_q;
	logic [2:0]       stg_q;
	logic             done_q;
	logic [RCP_W-1:0] qe;
	logic [DIV_W-1:0] rem;
	logic             bump;

	// estimate is the true quotient or one below it
	assign qe   = prod_s1[PRD_W-1:DIV_W];
	assign rem  = dvd_q - qd_s2[DIV_W-1:0];
	assign bump = (rem >= DIV_W'(dvs_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q  <= '0;
			done_q <= 1'b0;
		end else begin
			stg_q  <= {stg_q[1:0], start};
			done_q <= stg_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rcp_q <= recip;
		end
		if (stg_q[0]) begin
			prod_s1 <= PRD_W'(dvd_q) * PRD_W'(rcp_q);
		end
		if (stg_q[1]) begin
			qe_s2 <= qe;
			qd_s2 <= QD_W'(qe) * QD_W'(dvs_q);
		end
		if (stg_q[2]) begin
			quo_q <= DIV_W'(qe_s2) + DIV_W'(bump);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/gdda_dp.sv -----
// ----------------------------------------------------------------------------
// Date datapath
// Day number conversion in both directions, stored date and result registers.
// ----------------------------------------------------------------------------
module gdda_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  gdda_pkg::dp_cmd_t  cmd,
	output gdda_pkg::dp_sts_t  sts,
	input  logic [1:0]         func,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic [13:0]        in_year,
	input  logic signed [22:0] day_shift,
	output logic [3:0]         out_month,
	output logic [4:0]         out_day,
	output logic [13:0]        out_year,
	output logic [22:0]        julian_day,
	output logic signed [22:0] day_difference,
	output logic               replaced_default,
	output logic               out_of_range
);
	import gdda_pkg::*;

	logic [1:0]         func_q;
	logic [3:0]         gm_q;
	logic [4:0]         gd_q;
	logic [13:0]        gy_q;
	logic signed [22:0] shift_q;

	logic [3:0]  st_month_q;
	logic [4:0]  st_day_q;
	logic [13:0] st_year_q;
	logic [22:0] st_jd_q;

	logic [23:0] base_q;
	logic [22:0] jdg_q;
	logic [7:0]  n_q;
	logic [15:0] l1_q;
	logic [6:0]  i_q;
	logic [11:0] l2_q;
	logic [4:0]  j_q;
	logic [11:0] k_q;
	logic        l3_q;

	logic              early;
	logic [14:0]       y4800;
	logic [14:0]       y4900;
	logic [25:0]       t1_full;
	logic [23:0]       base_nxt;
	logic [9:0]        q3;
	logic [23:0]       jdg_nxt;
	logic signed [24:0] sum;
	logic              oor;
	logic [22:0]       rsrc;
	logic [23:0]       l0;
	logic [25:0]       n_prod;
	logic [23:0]       l1_nxt;
	logic [17:0]       i_prod;
	logic [15:0]       l2_nxt;
	logic [11:0]       k_nxt;
	logic [4:0]        mo;
	logic [17:0]       yr;
	logic              valid;
	logic signed [24:0] d_full;
	logic [22:0]       diff_sat;

	logic [DIV_W-1:0] dvd;
	logic [DVS_W-1:0] dvs;
	logic [RCP_W-1:0] rcp;
	logic [DIV_W-1:0] quo;
	logic             div_done;

	logic [3:0]  nx_month;
	logic [4:0]  nx_day;
	logic [13:0] nx_year;
	logic [22:0] nx_jd;
	logic [22:0] nx_diff;
	logic        nx_repl;
	logic        nx_oor;

	// given date to day number
	assign early    = (gm_q <= 4'd2);
	assign y4800    = {1'b0, gy_q} + 15'd4800 - {14'b0, early};
	assign y4900    = {1'b0, gy_q} + 15'd4900 - {14'b0, early};
	assign t1_full  = 26'(y4800) * 26'd1461;
	assign base_nxt = 24'(t1_full >> 2) + 24'(month_term(gm_q)) + 24'(gd_q) - 24'd32075;
	assign q3       = 10'(quo[7:0]) * 10'd3;
	assign jdg_nxt  = base_q - 24'(q3 >> 2);

	assign sum = $signed({2'b00, st_jd_q}) + $signed({{2{shift_q[22]}}, shift_q});
	assign oor = (sum < $signed({2'b00, JD_MIN})) || (sum > $signed({2'b00, JD_MAX}));

	// day number to date
	assign rsrc   = (func_q == FUNC_ADD) ? sum[22:0] : jdg_q;
	assign l0     = {1'b0, rsrc} + 24'd68569;
	assign n_prod = 26'(quo[7:0]) * 26'd146097 + 26'd3;
	assign l1_nxt = l0 - 24'(n_prod >> 2);
	assign i_prod = 18'(quo[6:0]) * 18'd1461;
	assign l2_nxt = l1_q - 16'(i_prod >> 2) + 16'd31;
	assign k_nxt  = l2_q - quo[11:0];

	assign mo = j_q + 5'd2 - (l3_q ? 5'd12 : 5'd0);
	assign yr = 18'(n_q) * 18'd100 - 18'd4900 + 18'(i_q) + 18'(l3_q);

	assign valid = (yr == 18'(gy_q)) && (mo == {1'b0, gm_q}) &&
		(k_q == 12'(gd_q)) && (gy_q <= YEAR_MAX);

	assign d_full = $signed({2'b00, jdg_q}) - $signed({2'b00, st_jd_q});

	always_comb begin
		if (d_full > $signed(25'sd4194303)) begin
			diff_sat = 23'h3FFFFF;
		end else if (d_full < $signed(-25'sd4194304)) begin
			diff_sat = 23'h400000;
		end else begin
			diff_sat = d_full[22:0];
		end
	end

	always_comb begin
		dvd = '0;
		dvs = '0;
		rcp = '0;
		unique case (cmd.step)
			STEP_FWD: begin
				dvd = DIV_W'(y4900);
				dvs = DVS_W'(100);
				rcp = RCP_100;
			end
			STEP_N: begin
				dvd = DIV_W'({l0, 2'b00});
				dvs = DVS_W'(146097);
				rcp = RCP_146097;
			end
			STEP_I: begin
				dvd = DIV_W'({1'b0, l1_q} + 17'd1) * DIV_W'(4000);
				dvs = DVS_W'(1461001);
				rcp = RCP_1461001;
			end
			STEP_J: begin
				dvd = DIV_W'(l2_q) * DIV_W'(80);
				dvs = DVS_W'(2447);
				rcp = RCP_2447;
			end
			STEP_K: begin
				dvd = DIV_W'(j_q) * DIV_W'(2447);
				dvs = DVS_W'(80);
				rcp = RCP_80;
			end
			STEP_L: begin
				dvd = DIV_W'(j_q);
				dvs = DVS_W'(11);
				rcp = RCP_11;
			end
			default: begin
				dvd = '0;
				dvs = DVS_W'(1);
				rcp = '0;
			end
		endcase
	end

	gdda_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.recip    (rcp),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		nx_month = st_month_q;
		nx_day   = st_day_q;
		nx_year  = st_year_q;
		nx_jd    = st_jd_q;
		nx_diff  = '0;
		nx_repl  = 1'b0;
		nx_oor   = 1'b0;
		unique case (func_q)
			FUNC_SET: begin
				if (valid) begin
					nx_month = gm_q;
					nx_day   = gd_q;
					nx_year  = gy_q;
					nx_jd    = jdg_q;
				end else begin
					nx_month = DEF_MONTH;
					nx_day   = DEF_DAY;
					nx_year  = DEF_YEAR;
					nx_jd    = DEF_JD;
					nx_repl  = 1'b1;
				end
			end
			FUNC_ADD: begin
				if (oor) begin
					nx_oor = 1'b1;
				end else begin
					nx_month = mo[3:0];
					nx_day   = k_q[4:0];
					nx_year  = yr[13:0];
					nx_jd    = sum[22:0];
				end
			end
			FUNC_DIFF: begin
				nx_diff = diff_sat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_month_q <= DEF_MONTH;
			st_day_q   <= DEF_DAY;
			st_year_q  <= DEF_YEAR;
			st_jd_q    <= DEF_JD;
		end else if (cmd.commit) begin
			st_month_q <= nx_month;
			st_day_q   <= nx_day;
			st_year_q  <= nx_year;
			st_jd_q    <= nx_jd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			gm_q    <= in_month;
			gd_q    <= in_day;
			gy_q    <= in_year;
			shift_q <= day_shift;
		end
		if (cmd.route) begin
			base_q <= base_nxt;
		end
		if (cmd.capture) begin
			unique case (cmd.step)
				STEP_FWD: jdg_q <= jdg_nxt[22:0];
				STEP_N: begin
					n_q  <= quo[7:0];
					l1_q <= l1_nxt[15:0];
				end
				STEP_I: begin
					i_q  <= quo[6:0];
					l2_q <= l2_nxt[11:0];
				end
				STEP_J:  j_q  <= quo[4:0];
				STEP_K:  k_q  <= k_nxt;
				STEP_L:  l3_q <= quo[0];
				default: begin
				end
			endcase
		end
		if (cmd.commit) begin
			out_month        <= nx_month;
			out_day          <= nx_day;
			out_year         <= nx_year;
			julian_day       <= nx_jd;
			day_difference   <= $signed(nx_diff);
			replaced_default <= nx_repl;
			out_of_range     <= nx_oor;
		end
	end

	assign sts.func     = func_q;
	assign sts.oor      = oor;
	assign sts.div_done = div_done;

endmodule

// ----- hw/rtl/gdda_ctrl.sv -----
// ----------------------------------------------------------------------------
// Date controller
// Sequences the divider steps per selector and runs both handshakes.
// ----------------------------------------------------------------------------
module gdda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output gdda_pkg::dp_cmd_t cmd,
	input  gdda_pkg::dp_sts_t sts
);
	import gdda_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ROUTE  = 5'b00010,
		S_START  = 5'b00100,
		S_WAIT   = 5'b01000,
		S_COMMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	step_t  step_q, step_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		cmd.step = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ROUTE;
				end
			end
			S_ROUTE: begin
				cmd.route = 1'b1;
				priority if (sts.func == FUNC_SET || sts.func == FUNC_DIFF) begin
					step_d  = STEP_FWD;
					state_d = S_START;
				end else if (sts.func == FUNC_ADD && !sts.oor) begin
					step_d  = STEP_N;
					state_d = S_START;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				if (sts.div_done) begin
					cmd.capture = 1'b1;
					state_d     = S_START;
					unique case (step_q)
						STEP_FWD: begin
							if (sts.func == FUNC_SET) begin
								step_d = STEP_N;
							end else begin
								state_d = S_COMMIT;
							end
						end
						STEP_N:  step_d = STEP_I;
						STEP_I:  step_d = STEP_J;
						STEP_J:  step_d = STEP_K;
						STEP_K:  step_d = STEP_L;
						default: state_d = S_COMMIT;
					endcase
				end
			end
			S_COMMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_FWD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/gregorian_date_day_arithmetic_core.sv -----
// Divisions in the shared divider: none for an add out of range or the unused
//   selector, one for difference, five for add, six for set.
// Throughput: one transaction at a time; the next is taken once the current one
//   has reached the output register.
// Reset: arst_n clears control and restores the stored date 5/11/1959.
// ----------------------------------------------------------------------------
// Gregorian date day arithmetic core
// Keeps one date; sets it, shifts it by days, or reports day differences.
// ----------------------------------------------------------------------------
module gregorian_date_day_arithmetic_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic [13:0]        in_year,
	input  logic signed [22:0] day_shift,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         out_month,
	output logic [4:0]         out_day,
	output logic [13:0]        out_year,
	output logic [22:0]        julian_day,
	output logic signed [22:0] day_difference,
	output logic               replaced_default,
	output logic               out_of_range
);
	import gdda_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gdda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	gdda_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.func             (func),
		.in_month         (in_month),
		.in_day           (in_day),
		.in_year          (in_year),
		.day_shift        (day_shift),
		.out_month        (out_month),
		.out_day          (out_day),
		.out_year         (out_year),
		.julian_day       (julian_day),
		.day_difference   (day_difference),
		.replaced_default (replaced_default),
		.out_of_range     (out_of_range)
	);

endmodule

// ----- hw/rtl/gdda_chk.sv -----
// ----------------------------------------------------------------------------
// Date core checker
// Port level properties of the date core, bound to the top level.
// ----------------------------------------------------------------------------
module gdda_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [3:0]         out_month,
	input logic [4:0]         out_day,
	input logic [13:0]        out_year,
	input logic [22:0]        julian_day,
	input logic signed [22:0] day_difference,
	input logic               replaced_default,
	input logic               out_of_range
);
	import gdda_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core took a second transaction without working the first");

	a_date_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 &&
		out_year <= YEAR_MAX && julian_day >= JD_MIN && julian_day <= JD_MAX)
		else $error("stored date out of range");

	a_default_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && replaced_default |-> out_month == DEF_MONTH && out_day == DEF_DAY &&
		out_year == DEF_YEAR && julian_day == DEF_JD)
		else $error("rejected set did not restore the default date");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (replaced_default || out_of_range) |->
		day_difference == 23'sd0 && !(replaced_default && out_of_range))
		else $error("flags and difference inconsistent");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(julian_day) &&
		$stable(day_difference))
		else $error("stalled result changed");

endmodule

bind gregorian_date_day_arithmetic_core gdda_chk u_gdda_chk (.*);

// ----- sim/gdda_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gregorian date core checker
// Watches both channels, predicts each result from the accepted input
// transaction with its own day-number model, and compares field by field.
// ----------------------------------------------------------------------------
module gdda_checker
	import gdda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic [13:0]       in_year,
	input  logic signed [22:0] day_shift,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [3:0]         out_month,
	input  logic [4:0]         out_day,
	input  logic [13:0]        out_year,
	input  logic [22:0]        julian_day,
	input  logic signed [22:0] day_difference,
	input  logic               replaced_default,
	input  logic               out_of_range,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [3:0]         month;
		logic [4:0]         day;
		logic [13:0]        year;
		logic [22:0]        jd;
		logic signed [22:0] diff;
		logic               repl;
		logic               oor;
	} date_result_t;

	date_result_t expected_q[$];
	logic [3:0]   cur_month;
	logic [4:0]   cur_day;
	logic [13:0]  cur_year;

	// truncating division on longint matches the formulas directly
	function automatic longint day_number(longint y, longint m, longint d);
		longint a;
		a = (m - 14) / 12;
		return d - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - a * 12) / 12
			- 3 * ((y + 4900 + a) / 100) / 4;
	endfunction

	task automatic civil_date(input longint jd, output longint y, output longint m,
			output longint d);
		longint l, n, i, j, k;
		l = jd + 68569;
		n = 4 * l / 146097;
		l = l - (146097 * n + 3) / 4;
		i = 4000 * (l + 1) / 1461001;
		l = l - 1461 * i / 4 + 31;
		j = 80 * l / 2447;
		k = l - 2447 * j / 80;
		l = j / 11;
		j = j + 2 - 12 * l;
		y = 100 * (n - 49) + i + l;
		m = j;
		d = k;
	endtask

	function automatic longint cur_jd();
		return day_number(cur_year, cur_month, cur_day);
	endfunction

	task automatic predict_date();
		date_result_t r;
		longint y, m, d, jd, df;
		r = '0;
		df = 0;
		case (func)
			FUNC_SET: begin
				civil_date(day_number(in_year, in_month, in_day), y, m, d);
				if (y == in_year && m == in_month && d == in_day && in_year <= YEAR_MAX) begin
					cur_month = in_month;
					cur_day = in_day;
					cur_year = in_year;
				end else begin
					cur_month = DEF_MONTH;
					cur_day = DEF_DAY;
					cur_year = DEF_YEAR;
					r.repl = 1'b1;
				end
			end
			FUNC_ADD: begin
				jd = cur_jd() + longint'(day_shift);
				if (jd < longint'(JD_MIN) || jd > longint'(JD_MAX))
					r.oor = 1'b1;
				else begin
					civil_date(jd, y, m, d);
					cur_month = 4'(m);
					cur_day = 5'(d);
					cur_year = 14'(y);
				end
			end
			FUNC_DIFF: begin
				df = day_number(in_year, in_month, in_day) - cur_jd();
				if (df > 4194303)
					df = 4194303;
				if (df < -4194304)
					df = -4194304;
			end
			default: ;
		endcase
		r.month = cur_month;
		r.day = cur_day;
		r.year = cur_year;
		r.jd = 23'(cur_jd());
		r.diff = 23'(df);
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		date_result_t e, a;
		if (!arst_n) begin
			cur_month = DEF_MONTH;
			cur_day = DEF_DAY;
			cur_year = DEF_YEAR;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				a = '{out_month, out_day, out_year, julian_day, day_difference,
					replaced_default, out_of_range};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", a);
				end else begin
					e = expected_q.pop_front();
					if (a !== e) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp %p act %p", e, a);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_date();
		end
		pending = expected_q.size();
	end

endmodule

// ----- sim/tb_gregorian_date_day_arithmetic_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gregorian date core testbench
// Directed and random set, add, difference and no-op transactions under random
// idling on both sides, with a long output hold-off; checked by gdda_checker.
// ----------------------------------------------------------------------------
module tb_gregorian_date_day_arithmetic_core;
	import gdda_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = FUNC_SET;
	logic [3:0]         in_month = '0;
	logic [4:0]         in_day = '0;
	logic [13:0]        in_year = '0;
	logic signed [22:0] day_shift = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [3:0]         out_month;
	logic [4:0]         out_day;
	logic [13:0]        out_year;
	logic [22:0]        julian_day;
	logic signed [22:0] day_difference;
	logic               replaced_default;
	logic               out_of_range;
	int                 fail_count;
	int                 pending;
	int                 send_idle = 0;
	int                 recv_idle = 0;
	int                 hold_cycles = 0;
	logic               hold_go = 1'b0;
	logic               hold_taken = 1'b0;
	longint             cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	gregorian_date_day_arithmetic_core u_dut (.*);

	gdda_checker u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= 2000;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic send_date(input logic [1:0] f, input logic [3:0] m, input logic [4:0] d,
			input logic [13:0] y, input logic signed [22:0] s);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		in_month <= m;
		in_day <= d;
		in_year <= y;
		day_shift <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic random_date();
		int r;
		logic [3:0] m;
		logic [4:0] d;
		logic [13:0] y;
		r = $urandom_range(99);
		m = (r < 80) ? 4'($urandom_range(12, 1)) : 4'($urandom);
		d = (r < 70) ? 5'($urandom_range(28, 1)) : 5'($urandom);
		y = (r < 85) ? 14'($urandom_range(9999)) : 14'($urandom);
		r = $urandom_range(99);
		if (r < 35)
			send_date(FUNC_SET, m, d, y, 23'($urandom));
		else if (r < 70)
			send_date(FUNC_ADD, m, d, y, ($urandom_range(3) == 0) ? 23'($urandom)
				: 23'(int'($urandom_range(200000)) - 100000));
		else if (r < 95)
			send_date(FUNC_DIFF, m, d, y, 23'($urandom));
		else
			send_date(FUNC_NONE, m, d, y, 23'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_date(FUNC_DIFF, 4'd5, 5'd11, 14'd1959, '0);
		send_date(FUNC_SET, 4'd2, 5'd29, 14'd2000, '0);
		send_date(FUNC_SET, 4'd2, 5'd29, 14'd1900, '0);
		send_date(FUNC_SET, 4'd0, 5'd0, 14'd0, '0);
		send_date(FUNC_SET, 4'd15, 5'd31, 14'd16383, '1);
		send_date(FUNC_SET, 4'd12, 5'd31, 14'd9999, '0);
		send_date(FUNC_ADD, 4'd0, 5'd0, 14'd0, 23'sd1);
		send_date(FUNC_DIFF, 4'd1, 5'd1, 14'd0, '0);
		send_date(FUNC_DIFF, 4'd15, 5'd31, 14'd16383, '0);
		send_date(FUNC_SET, 4'd1, 5'd1, 14'd0, '0);
		send_date(FUNC_ADD, 4'd0, 5'd0, 14'd0, -23'sd1);
		send_date(FUNC_ADD, 4'd0, 5'd0, 14'd0, 23'sd3652424);
		send_date(FUNC_ADD, 4'd0, 5'd0, 14'd0, -23'sd3652424);
		send_date(FUNC_ADD, 4'd0, 5'd0, 14'd0, 23'h3FFFFF);
		send_date(FUNC_ADD, 4'd0, 5'd0, 14'd0, 23'h400000);
		send_date(FUNC_DIFF, 4'd0, 5'd0, 14'd0, '0);
		send_date(FUNC_NONE, 4'd15, 5'd31, 14'd16383, '1);
		send_date(FUNC_SET, 4'd4, 5'd31, 14'd2023, '0);
		send_date(FUNC_SET, 4'd13, 5'd1, 14'd2023, '0);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 28 : (ph == 1) ? 58 : 0;
			recv_idle = (ph == 0) ? 58 : (ph == 1) ? 28 : 0;
			if (ph == 1)
				hold_go <= 1'b1;
			for (int i = 0; i < 660; i++)
				random_date();
		end
		in_valid <= 1'b0;
		while (pending != 0 || hold_cycles != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
